// ----- sv/timed_sample_logger_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Timed sample logger assertion macros
// Shared assertion shorthands. Assertions are removed when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef TIMED_SAMPLE_LOGGER_UNIT_DEFINES_SVH
`define TIMED_SAMPLE_LOGGER_UNIT_DEFINES_SVH

`ifndef SYNTH
// Condition must hold at every clock edge out of reset.
`define TSLU_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define TSLU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TSLU_ASSERT(lbl, cond, msg)
`define TSLU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- sv/tslu_pkg.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger package
// Types, codes and constants shared by the logger front, queue and back.
// ----------------------------------------------------------------------------
package tslu_pkg;

	localparam int WORD_W     = 32;
	localparam int TIME_W     = 40;
	localparam int SMP_W      = 16;
	localparam int MASK_W     = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int NUM_CHANNELS = 2;
	localparam int QUEUE_DEPTH_DEF = 2;

	// Column enables that belong to an existing channel
	localparam logic [MASK_W-1:0] CHAN_MASK = (NUM_CHANNELS >= 2) ? 7'h77 : 7'h07;

	localparam logic [WORD_W-1:0] HDR_MAGIC_A = 32'h2D5A4545;
	localparam logic [WORD_W-1:0] HDR_MAGIC_B = 32'h474F4C44;
	localparam logic [WORD_W-1:0] HDR_VERSION = 32'h00000001;

	localparam logic [MASK_W-1:0] RST_COLUMN_MASK = '0;
	localparam logic [WORD_W-1:0] RST_PERIOD_US   = 32'd1000000;
	localparam logic [WORD_W-1:0] RST_DURATION_US = 32'd60000000;
	localparam logic              RST_TRIG_IMM    = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_US   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DURATION_US = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_IMM    = 2'd3;

	// Output word slots: seven header words, gap word, six columns
	localparam int NUM_POS = 14;
	localparam int POS_W   = 4;
	localparam logic [POS_W-1:0] POS_HDR_A    = 4'd0;
	localparam logic [POS_W-1:0] POS_HDR_B    = 4'd1;
	localparam logic [POS_W-1:0] POS_VERSION  = 4'd2;
	localparam logic [POS_W-1:0] POS_COLS     = 4'd3;
	localparam logic [POS_W-1:0] POS_PERIOD   = 4'd4;
	localparam logic [POS_W-1:0] POS_DURATION = 4'd5;
	localparam logic [POS_W-1:0] POS_UTC      = 4'd6;
	localparam logic [POS_W-1:0] POS_GAP      = 4'd7;
	localparam logic [POS_W-1:0] POS_V0       = 4'd8;
	localparam logic [POS_W-1:0] POS_I0       = 4'd9;
	localparam logic [POS_W-1:0] POS_P0       = 4'd10;
	localparam logic [POS_W-1:0] POS_V1       = 4'd11;
	localparam logic [POS_W-1:0] POS_I1       = 4'd12;
	localparam logic [POS_W-1:0] POS_P1       = 4'd13;
	localparam int NUM_HDR = 7;

	typedef enum logic [1:0] {
		ACT_INIT  = 2'd0,
		ACT_TRIG  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_ABORT = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MODE_IDLE      = 2'd0,
		MODE_ARMED     = 2'd1,
		MODE_TRIGGERED = 2'd2,
		MODE_LOGGING   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_GAP    = 2'd1,
		KIND_SAMPLE = 2'd2,
		KIND_STATUS = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_EVAL,
		F_CMP,
		F_LIM,
		F_DIV,
		F_END,
		F_PUSH
	} fstate_t;

	// One queued job: everything the back needs to emit the words of an item
	typedef struct packed {
		logic              hdr;
		logic              smp;
		logic              err;
		mode_t             mode;
		logic [MASK_W-1:0] cols;
		logic [WORD_W-1:0] missed;
		logic [WORD_W-1:0] period;
		logic [WORD_W-1:0] duration;
		logic [WORD_W-1:0] utc;
		logic [SMP_W-1:0]  volt0;
		logic [SMP_W-1:0]  curr0;
		logic [SMP_W-1:0]  volt1;
		logic [SMP_W-1:0]  curr1;
	} job_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] quotient;
		logic [WORD_W-1:0] remainder;
	} div_rsp_t;

endpackage

// ----- sv/tslu_div.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger divider
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tslu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tslu_pkg::div_req_t req,
	output tslu_pkg::div_rsp_t rsp
);
	import tslu_pkg::*;

	localparam int CNT_W = $clog2(WORD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] dvs_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;

	assign trial = {rem_q, quo_q[WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(WORD_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			// keep the trial value when the subtract underflows
			if (!diff[WORD_W]) begin
				rem_q <= diff[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ----- sv/tslu_front.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger front
// Accepts actions, runs the mode and timing state and queues one job per item.
// ----------------------------------------------------------------------------
module tslu_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic                             start_now,
	input  logic [tslu_pkg::WORD_W-1:0]      tick_us,
	input  logic [tslu_pkg::WORD_W-1:0]      utc_seconds,
	input  logic [tslu_pkg::SMP_W-1:0]       volt_ch0,
	input  logic [tslu_pkg::SMP_W-1:0]       curr_ch0,
	input  logic [tslu_pkg::SMP_W-1:0]       volt_ch1,
	input  logic [tslu_pkg::SMP_W-1:0]       curr_ch1,
	input  logic                             cfg_we,
	input  logic [tslu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [tslu_pkg::WORD_W-1:0]      cfg_wdata,
	output logic                             push,
	output tslu_pkg::job_t                   job,
	input  logic                             full,
	output tslu_pkg::div_req_t               div_req,
	input  tslu_pkg::div_rsp_t               div_rsp
);
	import tslu_pkg::*;

	fstate_t           state_q, state_d;
	mode_t             mode_q;
	logic [WORD_W-1:0] prev_tick_q;
	logic [TIME_W-1:0] elapsed_q;
	logic [TIME_W-1:0] next_q;
	logic [WORD_W-1:0] lim_q;
	logic [WORD_W-1:0] missed_q;
	logic              hdr_q, smp_q, err_q;

	action_t           action_q;
	logic              start_now_q;
	logic [WORD_W-1:0] tick_q, utc_q;
	logic [SMP_W-1:0]  volt0_q, curr0_q, volt1_q, curr1_q;

	logic [MASK_W-1:0] mask_q;
	logic [WORD_W-1:0] period_q, duration_q;
	logic              trig_imm_q;

	logic              accept;
	logic [MASK_W-1:0] cols;
	logic              no_cols;
	logic [WORD_W-1:0] per_eff;
	logic              do_start, do_tick;
	logic              hit, lim_ge;
	logic [TIME_W-1:0] dur_ext;
	logic [WORD_W:0]   next_sum;

	assign accept   = in_valid && in_ready;
	assign cols     = mask_q & CHAN_MASK;
	assign no_cols  = (cols == '0);
	assign per_eff  = (period_q == '0) ? WORD_W'(1) : period_q;
	assign dur_ext  = {{(TIME_W-WORD_W){1'b0}}, duration_q};
	assign do_start = (action_q == ACT_INIT && trig_imm_q) ||
		(action_q == ACT_TRIG && start_now_q) ||
		(action_q == ACT_TICK && mode_q == MODE_TRIGGERED);
	assign do_tick  = (action_q == ACT_TICK) && (mode_q == MODE_LOGGING);
	assign hit      = (elapsed_q >= next_q);
	assign lim_ge   = ({{(TIME_W-WORD_W){1'b0}}, lim_q} >= next_q);
	// next sample time after a gap: lim - (lim - next) % p + p
	assign next_sum = {1'b0, lim_q - div_rsp.remainder} + {1'b0, per_eff};

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (accept) state_d = F_EVAL;
			F_EVAL: state_d = (!do_start && do_tick) ? F_CMP : F_PUSH;
			F_CMP:  state_d = hit ? F_LIM : F_PUSH;
			F_LIM:  state_d = lim_ge ? F_DIV : F_END;
			F_DIV:  if (div_rsp.done) state_d = F_END;
			F_END:  state_d = F_PUSH;
			F_PUSH: if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == F_IDLE);
		push             = (state_q == F_PUSH) && !full;
		div_req.start    = (state_q == F_LIM) && lim_ge;
		div_req.dividend = lim_q - next_q[WORD_W-1:0];
		div_req.divisor  = per_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= F_IDLE;
			mode_q      <= MODE_IDLE;
			prev_tick_q <= '0;
			elapsed_q   <= '0;
			next_q      <= '0;
			mask_q      <= RST_COLUMN_MASK;
			period_q    <= RST_PERIOD_US;
			duration_q  <= RST_DURATION_US;
			trig_imm_q  <= RST_TRIG_IMM;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_idx)
					REG_COLUMN_MASK: mask_q     <= cfg_wdata[MASK_W-1:0];
					REG_PERIOD_US:   period_q   <= cfg_wdata;
					REG_DURATION_US: duration_q <= cfg_wdata;
					REG_TRIG_IMM:    trig_imm_q <= cfg_wdata[0];
					default:         ;
				endcase
			end
			case (state_q)
				F_EVAL: begin
					if (do_start) begin
						if (!no_cols) begin
							// first sample lands at time zero with no gap
							mode_q      <= (per_eff > duration_q) ? MODE_IDLE : MODE_LOGGING;
							prev_tick_q <= tick_q;
							elapsed_q   <= '0;
							next_q      <= {{(TIME_W-WORD_W){1'b0}}, per_eff};
						end
					end else begin
						case (action_q)
							ACT_INIT:  if (!no_cols) mode_q <= MODE_ARMED;
							ACT_TRIG:  mode_q <= MODE_TRIGGERED;
							ACT_TICK: begin
								if (do_tick) begin
									elapsed_q   <= elapsed_q +
										{{(TIME_W-WORD_W){1'b0}}, tick_q - prev_tick_q};
									prev_tick_q <= tick_q;
								end
							end
							ACT_ABORT: mode_q <= MODE_IDLE;
							default:   ;
						endcase
					end
				end
				F_LIM: begin
					if (!lim_ge) next_q <= next_q + {{(TIME_W-WORD_W){1'b0}}, per_eff};
				end
				F_DIV: begin
					if (div_rsp.done) next_q <= {{(TIME_W-WORD_W-1){1'b0}}, next_sum};
				end
				F_END: begin
					if (next_q > dur_ext) mode_q <= MODE_IDLE;
				end
				default: ;
			endcase
		end
	end

	// job payload
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q    <= action_t'(action);
			start_now_q <= start_now;
			tick_q      <= tick_us;
			utc_q       <= utc_seconds;
			volt0_q     <= volt_ch0;
			curr0_q     <= curr_ch0;
			volt1_q     <= volt_ch1;
			curr1_q     <= curr_ch1;
		end
		case (state_q)
			F_EVAL: begin
				missed_q <= '0;
				hdr_q    <= do_start && !no_cols;
				smp_q    <= do_start && !no_cols;
				err_q    <= no_cols && (do_start || action_q == ACT_INIT);
			end
			F_CMP: begin
				smp_q <= hit;
				lim_q <= (elapsed_q < dur_ext) ? elapsed_q[WORD_W-1:0] : duration_q;
			end
			F_DIV: if (div_rsp.done) missed_q <= div_rsp.quotient;
			default: ;
		endcase
	end

	always_comb begin
		job          = '0;
		job.hdr      = hdr_q;
		job.smp      = smp_q;
		job.err      = err_q;
		job.mode     = mode_q;
		job.cols     = cols;
		job.missed   = missed_q;
		job.period   = per_eff;
		job.duration = duration_q;
		job.utc      = utc_q;
		job.volt0    = volt0_q;
		job.curr0    = curr0_q;
		job.volt1    = volt1_q;
		job.curr1    = curr1_q;
	end

endmodule

// ----- sv/tslu_fifo.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger job queue
// Short queue between the front and back; the head entry is read in place.
// ----------------------------------------------------------------------------
`include "timed_sample_logger_unit_defines.svh"

module tslu_fifo #(
	parameter int DEPTH = tslu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tslu_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output tslu_pkg::job_t head_job
);
	import tslu_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	`TSLU_ASSERT(a_count_range, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`TSLU_ASSERT(a_no_overflow, !(push && full), "push into a full queue")
	`TSLU_ASSERT(a_no_underflow, !(pop && !head_valid), "pop from an empty queue")

endmodule

// ----- sv/tslu_back.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger back
// Expands the head job into result words, one word per cycle when not stalled.
// ----------------------------------------------------------------------------
`include "timed_sample_logger_unit_defines.svh"

module tslu_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  tslu_pkg::job_t              q_job,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [tslu_pkg::WORD_W-1:0] word,
	output logic                        error_code,
	output logic [1:0]                  mode_now,
	output logic                        last_word
);
	import tslu_pkg::*;

	logic               loaded_q;
	logic [NUM_POS-1:0] rem_q;
	logic               out_valid_q;
	kind_t              kind_q;
	logic [WORD_W-1:0]  word_q;
	logic               err_q;
	mode_t              mode_q;
	logic               last_q;

	logic [NUM_POS-1:0] en, work, low, remaining;
	logic [POS_W-1:0]   idx;
	logic               status;
	logic               advance;
	logic [SMP_W-1:0]   mul_a, mul_b;
	logic [WORD_W-1:0]  prod;
	kind_t              kind_d;
	logic [WORD_W-1:0]  word_d;

	always_comb begin
		en = '0;
		en[NUM_HDR-1:0] = {NUM_HDR{q_job.hdr}};
		en[POS_GAP] = q_job.smp;
		en[POS_V0]  = q_job.smp && q_job.cols[0];
		en[POS_I0]  = q_job.smp && q_job.cols[1];
		en[POS_P0]  = q_job.smp && q_job.cols[2];
		en[POS_V1]  = q_job.smp && q_job.cols[4];
		en[POS_I1]  = q_job.smp && q_job.cols[5];
		en[POS_P1]  = q_job.smp && q_job.cols[6];
	end

	assign work      = loaded_q ? rem_q : en;
	assign low       = work & (~work + 1'b1);
	assign remaining = work & ~low;
	assign status    = (work == '0);
	assign advance   = q_valid && (!out_valid_q || out_ready);
	assign pop       = advance && (remaining == '0);

	always_comb begin
		idx = '0;
		for (int i = NUM_POS - 1; i >= 0; i--) begin
			if (work[i]) idx = POS_W'(i);
		end
	end

	assign mul_a = (idx >= POS_V1) ? q_job.volt1 : q_job.volt0;
	assign mul_b = (idx >= POS_V1) ? q_job.curr1 : q_job.curr0;
	assign prod  = {{(WORD_W-SMP_W){1'b0}}, mul_a} * {{(WORD_W-SMP_W){1'b0}}, mul_b};

	always_comb begin
		kind_d = KIND_SAMPLE;
		word_d = '0;
		case (idx)
			POS_HDR_A:    begin kind_d = KIND_HEADER; word_d = HDR_MAGIC_A; end
			POS_HDR_B:    begin kind_d = KIND_HEADER; word_d = HDR_MAGIC_B; end
			POS_VERSION:  begin kind_d = KIND_HEADER; word_d = HDR_VERSION; end
			POS_COLS: begin
				kind_d = KIND_HEADER;
				word_d = {{(WORD_W-MASK_W){1'b0}}, q_job.cols};
			end
			POS_PERIOD:   begin kind_d = KIND_HEADER; word_d = q_job.period; end
			POS_DURATION: begin kind_d = KIND_HEADER; word_d = q_job.duration; end
			POS_UTC:      begin kind_d = KIND_HEADER; word_d = q_job.utc; end
			POS_GAP:      begin kind_d = KIND_GAP; word_d = q_job.missed; end
			POS_V0:       word_d = {{(WORD_W-SMP_W){1'b0}}, q_job.volt0};
			POS_I0:       word_d = {{(WORD_W-SMP_W){1'b0}}, q_job.curr0};
			POS_V1:       word_d = {{(WORD_W-SMP_W){1'b0}}, q_job.volt1};
			POS_I1:       word_d = {{(WORD_W-SMP_W){1'b0}}, q_job.curr1};
			POS_P0, POS_P1: word_d = prod;
			default:      word_d = '0;
		endcase
		if (status) begin
			kind_d = KIND_STATUS;
			word_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			loaded_q    <= !pop;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rem_q  <= remaining;
			kind_q <= kind_d;
			word_q <= word_d;
			err_q  <= status && q_job.err;
			mode_q <= q_job.mode;
			last_q <= (remaining == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign word       = word_q;
	assign error_code = err_q;
	assign mode_now   = mode_q;
	assign last_word  = last_q;

	`TSLU_ASSERT(a_loaded_has_job, !loaded_q || q_valid, "partly sent job left the queue")
	`TSLU_ASSERT(a_loaded_has_words, !loaded_q || (|rem_q), "partly sent job has no words left")
	`TSLU_ASSERT_NEXT(a_pop_marks_last, pop, out_valid_q && last_q, "job ended without last word")

endmodule

// ----- sv/timed_sample_logger_unit.sv -----
// ----------------------------------------------------------------------------
// Timed sample logger unit
// Periodic data-logging sequencer: header, gap count, column and status words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one action per transfer:
//   initiate, trigger, tick or abort, with tick counter, UTC and readings.
//   Output channel (out_valid/out_ready) returns one word per transfer;
//   last_word marks the final word of an action, mode_now the mode after it.
//   Registers are written through cfg_we/cfg_idx/cfg_wdata while idle.
// Timing:
//   The front steps a plain action through evaluate and push, a tick that does
//   not reach the next sample time through evaluate, compare and push, and one
//   that does through compare, limit, divide, end and push (limit straight to
//   end when the duration already lies below the next sample time): the gap
//   count comes from a radix-2 divider at one quotient bit per cycle. The back
//   emits one word per cycle unless out_ready stalls it, up to 14 per action.
// Reset: mode idle, times cleared, registers at their reset values; no
//   clearing pass, inputs are taken from the first cycle after reset.
// Stall: a waiting output word is held; the job queue lets the front finish
//   further actions until it fills, then in_ready stays low.
// ----------------------------------------------------------------------------
module timed_sample_logger_unit #(
	parameter int QUEUE_DEPTH = tslu_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic        start_now,
	input  logic [31:0] tick_us,
	input  logic [31:0] utc_seconds,
	input  logic [15:0] volt_ch0,
	input  logic [15:0] curr_ch0,
	input  logic [15:0] volt_ch1,
	input  logic [15:0] curr_ch1,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] word,
	output logic        error_code,
	output logic [1:0]  mode_now,
	output logic        last_word,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_wdata
);
	import tslu_pkg::*;

	job_t     push_job, head_job;
	logic     push, full, pop, head_valid;
	div_req_t div_req;
	div_rsp_t div_rsp;

	tslu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.start_now   (start_now),
		.tick_us     (tick_us),
		.utc_seconds (utc_seconds),
		.volt_ch0    (volt_ch0),
		.curr_ch0    (curr_ch0),
		.volt_ch1    (volt_ch1),
		.curr_ch1    (curr_ch1),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.job         (push_job),
		.full        (full),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	tslu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tslu_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	tslu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (head_valid),
		.q_job      (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.word       (word),
		.error_code (error_code),
		.mode_now   (mode_now),
		.last_word  (last_word)
	);

endmodule
